FILE: design/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and keyword table of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_TOKEN_LEN_DEF = 255;

    // result queue depth, a power of two
    localparam int Q_DEPTH = 4;

    typedef enum logic [4:0] {
        TK_INT, TK_FLOAT, TK_DOUBLE, TK_EQ, TK_BOOL, TK_CHAR, TK_CHARLIT, TK_ID,
        TK_NUM, TK_IF, TK_ELSE, TK_WHILE, TK_FOR, TK_RETURN, TK_ASSIGN,
        TK_PLUS, TK_MINUS, TK_STAR, TK_DIV, TK_LPAREN, TK_RPAREN, TK_LBRACE,
        TK_RBRACE, TK_SEMI, TK_GT, TK_LT, TK_EOF, TK_ERROR
    } t_tok_kind;

    typedef enum logic [2:0] {
        ERR_NONE, ERR_UNEXPECTED, ERR_UNTERM, ERR_ESC_END, ERR_ESC_BAD
    } t_err;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_EQ, M_NUM, M_WORD, M_COMMENT,
        M_QOPEN, M_QESC, M_QCLOSE, M_HALT
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        t_tok_kind   token_kind;
        logic [15:0] line;
        logic [15:0] start_offset;
        logic [7:0]  token_length;
        logic [7:0]  char_value;
        t_err        error_code;
        logic        last;
    } t_res;

    // results of one accepted word, slot 0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

    // keyword text with byte 0 in the low bits
    typedef struct packed {
        logic [5:0][7:0] text;
        logic [2:0]      len;
        t_tok_kind       kind;
    } t_kw;

    localparam t_kw KW_TABLE [10] = '{
        '{48'("tni"),    3'd3, TK_INT},
        '{48'("taolf"),  3'd5, TK_FLOAT},
        '{48'("rga"),    3'd3, TK_IF},
        '{48'("anrew"),  3'd5, TK_ELSE},
        '{48'("nruter"), 3'd6, TK_RETURN},
        '{48'("elbuod"), 3'd6, TK_DOUBLE},
        '{48'("elihw"),  3'd5, TK_WHILE},
        '{48'("rof"),    3'd3, TK_FOR},
        '{48'("loob"),   3'd4, TK_BOOL},
        '{48'("rahc"),   3'd4, TK_CHAR}
    };

    // count 7 marks a word longer than six bytes
    function automatic t_tok_kind kw_kind(logic [5:0][7:0] pfx, logic [2:0] cnt);
        t_tok_kind k;
        logic      hit;
        logic      found;
        k     = TK_ID;
        found = 1'b0;
        for (int i = 0; i < 10; i++) begin
            hit = (KW_TABLE[i].len == cnt);
            for (int j = 0; j < 6; j++) begin
                if ((3'(j) < cnt) && (KW_TABLE[i].text[j] != pfx[j])) begin
                    hit = 1'b0;
                end
            end
            if (hit && !found) begin
                k     = KW_TABLE[i].kind;
                found = 1'b1;
            end
        end
        return k;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

endpackage
`default_nettype wire

FILE: design/stt_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_lexer
// Lexer state and token decision; yields up to two results per source word.
// ----------------------------------------------------------------------------
module stt_lexer import stt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_in   i_word,
    output t_push      o_push
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    t_mode                    r_mode, n_mode;
    logic [15:0]              r_line, n_line;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_tstart, n_tstart;
    logic [15:0]              r_tline, n_tline;
    logic [LW-1:0]            r_tlen, n_tlen;
    logic [7:0]               r_lit, n_lit;
    logic [2:0]               r_pcnt, n_pcnt;
    logic [5:0][7:0]          r_prefix, n_prefix;

    logic [7:0]    w_ch;
    logic          w_src;
    logic          w_idle;
    logic          w_nl, w_ws, w_pending;
    logic [LW-1:0] w_grown;
    logic [15:0]   w_line_inc;
    t_tok_kind     w_single;
    t_tok_kind     w_kw;

    logic          w_f_v, w_s_v;
    t_res          w_f, w_s;

    assign w_ch       = i_word.ch;
    assign w_src      = i_accept && !i_word.kind;
    assign w_nl       = (w_ch == "\n");
    assign w_ws       = (w_ch == " ") || (w_ch == "\t") || (w_ch == 8'h0B) ||
                        (w_ch == 8'h0C) || (w_ch == 8'h0D);
    assign w_pending  = (w_ch == "/") || (w_ch == "=") || (w_ch == "'") ||
                        is_digit(w_ch) || is_alpha(w_ch);
    assign w_grown    = (r_tlen < LW'(MAX_TOKEN_LEN)) ? r_tlen + 1'b1 : r_tlen;
    assign w_line_inc = (r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;
    assign w_kw       = kw_kind(r_prefix, r_pcnt);

    always_comb begin
        case (w_ch)
            "+":     w_single = TK_PLUS;
            "-":     w_single = TK_MINUS;
            "*":     w_single = TK_STAR;
            "(":     w_single = TK_LPAREN;
            ")":     w_single = TK_RPAREN;
            "{":     w_single = TK_LBRACE;
            "}":     w_single = TK_RBRACE;
            ";":     w_single = TK_SEMI;
            ">":     w_single = TK_GT;
            "<":     w_single = TK_LT;
            default: w_single = TK_ERROR;
        endcase
    end

    // byte is handled from idle, after any pending token is closed
    always_comb begin
        w_idle = 1'b0;
        if (w_src) begin
            case (r_mode)
                M_IDLE:  w_idle = 1'b1;
                M_SLASH: w_idle = (w_ch != "/");
                M_EQ:    w_idle = (w_ch != "=");
                M_NUM:   w_idle = !is_digit(w_ch);
                M_WORD:  w_idle = !(is_alpha(w_ch) || is_digit(w_ch));
                default: w_idle = 1'b0;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_tlen   = r_tlen;
        n_lit    = r_lit;
        n_pcnt   = r_pcnt;
        n_prefix = r_prefix;
        if (i_accept && i_word.kind) begin
            n_mode   = M_IDLE;
            n_line   = 16'd1;
            n_pos    = '0;
            n_tstart = '0;
            n_tline  = 16'd1;
            n_tlen   = '0;
            n_lit    = '0;
            n_pcnt   = '0;
        end else if (w_src) begin
            if (r_mode != M_HALT && r_pos != '1) begin
                n_pos = r_pos + 1'b1;
            end
            case (r_mode)
                M_SLASH: begin
                    if (w_ch == "/") n_mode = M_COMMENT;
                end
                M_EQ: begin
                    if (w_ch == "=") begin
                        n_tlen = LW'(2);
                        n_mode = M_IDLE;
                    end
                end
                M_NUM: begin
                    if (is_digit(w_ch)) n_tlen = w_grown;
                end
                M_WORD: begin
                    if (is_alpha(w_ch) || is_digit(w_ch)) begin
                        n_tlen = w_grown;
                        if (r_pcnt < 3'd6) n_prefix[r_pcnt] = w_ch;
                        if (r_pcnt < 3'd7) n_pcnt = r_pcnt + 3'd1;
                    end
                end
                M_COMMENT: begin
                    if (w_nl) begin
                        n_line = w_line_inc;
                        n_mode = M_IDLE;
                    end
                end
                M_QOPEN: begin
                    n_tlen = w_grown;
                    if (w_nl) begin
                        n_mode = M_HALT;
                    end else if (w_ch == "\\") begin
                        n_mode = M_QESC;
                    end else begin
                        n_lit  = w_ch;
                        n_mode = M_QCLOSE;
                    end
                end
                M_QESC: begin
                    n_tlen = w_grown;
                    n_mode = M_QCLOSE;
                    if (w_ch == "n") begin
                        n_lit = "\n";
                    end else if (w_ch == "t") begin
                        n_lit = "\t";
                    end else if (w_ch == "'" || w_ch == "\\") begin
                        n_lit = w_ch;
                    end else begin
                        n_mode = M_HALT;
                    end
                end
                M_QCLOSE: begin
                    n_tlen = w_grown;
                    n_mode = (w_ch == "'") ? M_IDLE : M_HALT;
                end
                default: ;
            endcase
            if (w_idle) begin
                n_mode = M_IDLE;
                if (w_nl) begin
                    n_line = w_line_inc;
                end else if (!w_ws) begin
                    n_tstart = r_pos;
                    n_tline  = r_line;
                    n_tlen   = LW'(1);
                    if (w_ch == "/") begin
                        n_mode = M_SLASH;
                    end else if (w_ch == "=") begin
                        n_mode = M_EQ;
                    end else if (is_digit(w_ch)) begin
                        n_mode = M_NUM;
                    end else if (w_ch == "'") begin
                        n_mode = M_QOPEN;
                    end else if (is_alpha(w_ch)) begin
                        n_mode      = M_WORD;
                        n_prefix[0] = w_ch;
                        n_pcnt      = 3'd1;
                    end else if (w_single == TK_ERROR) begin
                        n_mode = M_HALT;
                    end
                end
            end
        end
    end

    // results: a closed pending token first, then a token of this byte or eof
    always_comb begin
        w_f_v              = 1'b0;
        w_f                = '0;
        w_f.line           = r_tline;
        w_f.start_offset   = 16'(r_tstart);
        w_f.token_length   = 8'(r_tlen);
        w_f.token_kind     = TK_ERROR;
        w_s_v              = 1'b0;
        w_s                = '0;
        w_s.line           = r_line;
        w_s.start_offset   = 16'(r_pos);
        w_s.token_length   = 8'd1;
        w_s.token_kind     = w_single;
        w_s.error_code     = (w_single == TK_ERROR) ? ERR_UNEXPECTED : ERR_NONE;
        if (i_accept && i_word.kind) begin
            case (r_mode)
                M_SLASH: begin
                    w_f_v = 1'b1;
                    w_f.token_kind = TK_DIV;
                end
                M_EQ: begin
                    w_f_v = 1'b1;
                    w_f.token_kind = TK_ASSIGN;
                end
                M_NUM: begin
                    w_f_v = 1'b1;
                    w_f.token_kind = TK_NUM;
                end
                M_WORD: begin
                    w_f_v = 1'b1;
                    w_f.token_kind = (r_pcnt <= 3'd6) ? w_kw : TK_ID;
                end
                M_QOPEN, M_QCLOSE: begin
                    w_f_v = 1'b1;
                    w_f.error_code = ERR_UNTERM;
                end
                M_QESC: begin
                    w_f_v = 1'b1;
                    w_f.error_code = ERR_ESC_END;
                end
                default: ;
            endcase
            w_s_v            = 1'b1;
            w_s.token_kind   = TK_EOF;
            w_s.token_length = 8'd0;
            w_s.error_code   = ERR_NONE;
        end else if (w_src) begin
            case (r_mode)
                M_SLASH: begin
                    w_f_v = w_idle;
                    w_f.token_kind = TK_DIV;
                end
                M_EQ: begin
                    w_f_v = 1'b1;
                    if (w_idle) begin
                        w_f.token_kind = TK_ASSIGN;
                    end else begin
                        w_f.token_kind   = TK_EQ;
                        w_f.token_length = 8'd2;
                    end
                end
                M_NUM: begin
                    w_f_v = w_idle;
                    w_f.token_kind = TK_NUM;
                end
                M_WORD: begin
                    w_f_v = w_idle;
                    w_f.token_kind = (r_pcnt <= 3'd6) ? w_kw : TK_ID;
                end
                M_QOPEN: begin
                    w_f_v = w_nl;
                    w_f.token_length = 8'(w_grown);
                    w_f.error_code   = ERR_UNTERM;
                end
                M_QESC: begin
                    w_f_v = !(w_ch == "n" || w_ch == "t" || w_ch == "'" || w_ch == "\\");
                    w_f.token_length = 8'(w_grown);
                    w_f.error_code   = ERR_ESC_BAD;
                end
                M_QCLOSE: begin
                    w_f_v = 1'b1;
                    w_f.token_length = 8'(w_grown);
                    if (w_ch == "'") begin
                        w_f.token_kind = TK_CHARLIT;
                        w_f.char_value = r_lit;
                    end else begin
                        w_f.error_code = ERR_UNTERM;
                    end
                end
                default: ;
            endcase
            w_s_v = w_idle && !w_nl && !w_ws && !w_pending;
        end

        o_push = '0;
        if (w_f_v && w_s_v) begin
            o_push.cnt     = 2'd2;
            o_push.r0      = w_f;
            o_push.r1      = w_s;
            o_push.r1.last = 1'b1;
        end else if (w_f_v) begin
            o_push.cnt     = 2'd1;
            o_push.r0      = w_f;
            o_push.r0.last = 1'b1;
        end else if (w_s_v) begin
            o_push.cnt     = 2'd1;
            o_push.r0      = w_s;
            o_push.r0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_line   <= 16'd1;
            r_pos    <= '0;
            r_tstart <= '0;
            r_tline  <= 16'd1;
            r_tlen   <= '0;
            r_lit    <= '0;
            r_pcnt   <= '0;
        end else begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_tlen   <= n_tlen;
            r_lit    <= n_lit;
            r_pcnt   <= n_pcnt;
        end
    end

    // prefix bytes are read only after they are written
    always_ff @(posedge i_clk) begin
        r_prefix <= n_prefix;
    end

endmodule
`default_nettype wire

FILE: design/stt_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_outq
// Result queue: takes up to two results a cycle, hands out one a cycle unless the reader stalls.
// ----------------------------------------------------------------------------
module stt_outq import stt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_full,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_res       o_word
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_res          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_pop;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];
    // keep room for a word that yields two results
    assign o_full  = (r_count > CW'(Q_DEPTH - 2));
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_wr    = r_wr + PW'(i_push.cnt);
        n_rd    = r_rd + PW'(w_pop);
        n_count = r_count + CW'(i_push.cnt) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.r0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + PW'(1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: design/source_text_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// path: the byte that closes a token writes it into the result queue, which feeds the output
// throughput: one source byte per cycle unless input stalls; a byte that
//   closes a pending token and starts a single-byte token yields two results,
//   which drain one per cycle unless the output stalls, through a four-entry
//   result queue, and input stalls while it holds more than two results
// reset: synchronous; lexer idle at line 1, position 0, result queue empty
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming lexer: source bytes in, tokens with line, offset and length out.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top import stt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_word,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_res      o_out_word
);

    t_push w_push;
    logic  w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    stt_lexer #(
        .POSITION_BITS(POSITION_BITS),
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_word  (i_in_word),
        .o_push  (w_push)
    );

    stt_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_full (o_in_stall),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_word (o_out_word)
    );

endmodule
`default_nettype wire

FILE: design/stt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker import stt_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire t_in  i_in_word,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_res o_out_word
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    // input is open right after reset
    a_reset_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // no result appears without an accepted word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !w_in_acc |=> !o_out_valid)
        else $error("result without input");

    // end of source always gives a result next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_word.kind |=> o_out_valid)
        else $error("end of source gave no result");

    // eof is the last result of its word
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.token_kind == TK_EOF |-> o_out_word.last)
        else $error("eof not marked last");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);
`default_nettype wire

FILE: tb/tb_source_text_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_top
// Self-checking bench for the streaming lexer. A short table of directed
// source words comes first, then random source text built mostly from valid
// lexemes, with broken literals and stray bytes mixed in. Every token is
// compared field by field with a typed row or a behavioral lexer in the bench.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_top;
    import stt_pkg::*;

    localparam int ITEMS     = 1300;
    localparam int CYC_LIMIT = 1000000;
    localparam t_res NO_TOK  = '0;

    typedef struct packed {
        t_in  word;
        logic chk;
        t_res exp;
    } t_row;

    // typed results only where they are obvious: fresh end, stray bytes, halt
    localparam t_row DIR_TAB [26] = '{
        '{'{1'b1, 8'h00}, 1'b1, '{TK_EOF, 16'd1, 16'd0, 8'd0, 8'd0, ERR_NONE, 1'b1}},
        '{'{1'b0, 8'hFF}, 1'b1,
          '{TK_ERROR, 16'd1, 16'd0, 8'd1, 8'd0, ERR_UNEXPECTED, 1'b1}},
        '{'{1'b0, "a"},   1'b0, NO_TOK},
        '{'{1'b1, 8'h00}, 1'b1, '{TK_EOF, 16'd1, 16'd1, 8'd0, 8'd0, ERR_NONE, 1'b1}},
        '{'{1'b0, 8'h00}, 1'b1,
          '{TK_ERROR, 16'd1, 16'd0, 8'd1, 8'd0, ERR_UNEXPECTED, 1'b1}},
        '{'{1'b1, 8'hFF}, 1'b1, '{TK_EOF, 16'd1, 16'd1, 8'd0, 8'd0, ERR_NONE, 1'b1}},
        '{'{1'b0, "="},   1'b0, NO_TOK},
        '{'{1'b0, "="},   1'b0, NO_TOK},
        '{'{1'b0, "="},   1'b0, NO_TOK},
        '{'{1'b0, "r"},   1'b0, NO_TOK},
        '{'{1'b0, "/"},   1'b0, NO_TOK},
        '{'{1'b0, "/"},   1'b0, NO_TOK},
        '{'{1'b0, 8'h0A}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h27}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h5C}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h27}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h27}, 1'b0, NO_TOK},
        '{'{1'b0, "9"},   1'b0, NO_TOK},
        '{'{1'b0, ";"},   1'b0, NO_TOK},
        '{'{1'b0, 8'h27}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h5C}, 1'b0, NO_TOK},
        '{'{1'b1, 8'h55}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h27}, 1'b0, NO_TOK},
        '{'{1'b0, 8'h0A}, 1'b0, NO_TOK},
        '{'{1'b0, "a"},   1'b0, NO_TOK},
        '{'{1'b1, 8'hAA}, 1'b0, NO_TOK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_word;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_word;

    source_text_tokenizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // behavioral lexer state
    t_mode       lx_mode;
    logic [15:0] lx_line;
    logic [15:0] lx_pos;
    logic [15:0] tok_start;
    logic [15:0] tok_line;
    logic [7:0]  tok_len;
    logic [7:0]  lit_byte;
    logic [7:0]  pfx [6];
    int          pfx_cnt;

    t_res step_toks [$];
    t_res exp_tokens [$];

    string     kw_text [10] = '{"int", "float", "agr", "werna", "return",
                                "double", "while", "for", "bool", "char"};
    t_tok_kind kw_tokens [10] = '{TK_INT, TK_FLOAT, TK_IF, TK_ELSE, TK_RETURN,
                                  TK_DOUBLE, TK_WHILE, TK_FOR, TK_BOOL, TK_CHAR};
    logic [7:0] op_bytes [10] = '{"+", "-", "*", "(", ")", "{", "}", ";", ">", "<"};
    logic [7:0] ws_bytes [6]  = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    int n_items    = 0;
    int n_fail     = 0;
    int n_cyc      = 0;
    int burst_left = 0;
    int rx_duty    = 0;

    function automatic bit digit_ch(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit letter_ch(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic void lx_reset();
        lx_mode   = M_IDLE;
        lx_line   = 16'd1;
        lx_pos    = 16'd0;
        tok_start = 16'd0;
        tok_line  = 16'd1;
        tok_len   = 8'd0;
        lit_byte  = 8'd0;
        pfx_cnt   = 0;
    endfunction

    function automatic void put_tok(t_tok_kind k, logic [15:0] ln, logic [15:0] st,
                                    logic [7:0] len, logic [7:0] cv, t_err e);
        t_res r;
        if (step_toks.size() >= 2) return;
        r.token_kind   = k;
        r.line         = ln;
        r.start_offset = st;
        r.token_length = len;
        r.char_value   = cv;
        r.error_code   = e;
        r.last         = 1'b0;
        step_toks.insert(step_toks.size(), r);
    endfunction

    function automatic void pending(t_tok_kind k);
        put_tok(k, tok_line, tok_start, tok_len, 8'd0, ERR_NONE);
    endfunction

    function automatic void raise_err(t_err e);
        put_tok(TK_ERROR, tok_line, tok_start, tok_len, 8'd0, e);
        lx_mode = M_HALT;
    endfunction

    function automatic void open_tok(t_mode m);
        tok_start = lx_pos;
        tok_line  = lx_line;
        tok_len   = 8'd1;
        lx_mode   = m;
    endfunction

    function automatic void lengthen();
        if (tok_len != 8'd255) tok_len++;
    endfunction

    function automatic void mark_last();
        t_res r;
        if (step_toks.size() == 0) return;
        r = step_toks.pop_back();
        r.last = 1'b1;
        step_toks.insert(step_toks.size(), r);
    endfunction

    // words longer than six bytes never match
    function automatic void word_done();
        t_tok_kind k;
        bit        hit;
        k = TK_ID;
        if (pfx_cnt <= 6) begin
            for (int i = 0; i < 10; i++) begin
                hit = (kw_text[i].len() == pfx_cnt);
                for (int j = 0; j < pfx_cnt; j++) begin
                    if (hit && (kw_text[i][j] != pfx[j])) hit = 1'b0;
                end
                if (hit) begin
                    k = kw_tokens[i];
                    break;
                end
            end
        end
        pending(k);
    endfunction

    function automatic void lx_idle(logic [7:0] c);
        t_tok_kind k;
        lx_mode = M_IDLE;
        if (c == 8'h0A) begin
            if (lx_line != 16'hFFFF) lx_line++;
            return;
        end
        if ((c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D))) return;
        if (c == "/") begin
            open_tok(M_SLASH);
            return;
        end
        if (c == "=") begin
            open_tok(M_EQ);
            return;
        end
        if (digit_ch(c)) begin
            open_tok(M_NUM);
            return;
        end
        if (c == 8'h27) begin
            open_tok(M_QOPEN);
            return;
        end
        if (letter_ch(c)) begin
            open_tok(M_WORD);
            pfx[0]  = c;
            pfx_cnt = 1;
            return;
        end
        case (c)
            "+": k = TK_PLUS;
            "-": k = TK_MINUS;
            "*": k = TK_STAR;
            "(": k = TK_LPAREN;
            ")": k = TK_RPAREN;
            "{": k = TK_LBRACE;
            "}": k = TK_RBRACE;
            ";": k = TK_SEMI;
            ">": k = TK_GT;
            "<": k = TK_LT;
            default: k = TK_ERROR;
        endcase
        open_tok(M_IDLE);
        if (k == TK_ERROR) raise_err(ERR_UNEXPECTED);
        else pending(k);
    endfunction

    // fills step_toks with the tokens of one word; returns 1 if it was ignored
    function automatic bit lx_step(t_in w);
        logic [7:0] c;
        c = w.ch;
        step_toks.delete();
        if (w.kind) begin
            case (lx_mode)
                M_SLASH: pending(TK_DIV);
                M_EQ: pending(TK_ASSIGN);
                M_NUM: pending(TK_NUM);
                M_WORD: word_done();
                M_QOPEN, M_QCLOSE: raise_err(ERR_UNTERM);
                M_QESC: raise_err(ERR_ESC_END);
                default: ;
            endcase
            put_tok(TK_EOF, lx_line, lx_pos, 8'd0, 8'd0, ERR_NONE);
            mark_last();
            lx_reset();
            return 1'b0;
        end
        if (lx_mode == M_HALT) return 1'b1;
        case (lx_mode)
            M_SLASH: begin
                if (c == "/") lx_mode = M_COMMENT;
                else begin
                    pending(TK_DIV);
                    lx_idle(c);
                end
            end
            M_EQ: begin
                if (c == "=") begin
                    tok_len = 8'd2;
                    pending(TK_EQ);
                    lx_mode = M_IDLE;
                end else begin
                    pending(TK_ASSIGN);
                    lx_idle(c);
                end
            end
            M_NUM: begin
                if (digit_ch(c)) lengthen();
                else begin
                    pending(TK_NUM);
                    lx_idle(c);
                end
            end
            M_WORD: begin
                if (digit_ch(c) || letter_ch(c)) begin
                    lengthen();
                    if (pfx_cnt < 6) pfx[pfx_cnt] = c;
                    if (pfx_cnt < 7) pfx_cnt++;
                end else begin
                    word_done();
                    lx_idle(c);
                end
            end
            M_COMMENT: begin
                if (c == 8'h0A) begin
                    if (lx_line != 16'hFFFF) lx_line++;
                    lx_mode = M_IDLE;
                end
            end
            M_QOPEN: begin
                lengthen();
                if (c == 8'h0A) raise_err(ERR_UNTERM);
                else if (c == 8'h5C) lx_mode = M_QESC;
                else begin
                    lit_byte = c;
                    lx_mode  = M_QCLOSE;
                end
            end
            M_QESC: begin
                lengthen();
                case (c)
                    "n": begin
                        lit_byte = 8'h0A;
                        lx_mode  = M_QCLOSE;
                    end
                    "t": begin
                        lit_byte = 8'h09;
                        lx_mode  = M_QCLOSE;
                    end
                    8'h27, 8'h5C: begin
                        lit_byte = c;
                        lx_mode  = M_QCLOSE;
                    end
                    default: raise_err(ERR_ESC_BAD);
                endcase
            end
            M_QCLOSE: begin
                lengthen();
                if (c == 8'h27) begin
                    put_tok(TK_CHARLIT, tok_line, tok_start, tok_len, lit_byte, ERR_NONE);
                    lx_mode = M_IDLE;
                end else raise_err(ERR_UNTERM);
            end
            default: lx_idle(c);
        endcase
        if (lx_pos != 16'hFFFF) lx_pos++;
        mark_last();
        return 1'b0;
    endfunction

    task automatic put_word(t_in w, logic chk, t_res typed);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!lx_step(w)) n_items++;
        if (chk) exp_tokens.insert(exp_tokens.size(), typed);
        else foreach (step_toks[i]) exp_tokens.insert(exp_tokens.size(), step_toks[i]);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic put_src(logic [7:0] c);
        t_in w;
        w.kind = 1'b0;
        w.ch   = c;
        put_word(w, 1'b0, NO_TOK);
    endtask

    task automatic put_end();
        t_in w;
        w.kind = 1'b1;
        w.ch   = 8'($urandom_range(0, 255));
        put_word(w, 1'b0, NO_TOK);
    endtask

    function automatic logic [7:0] rnd_alnum(bit letter_only);
        int r;
        r = letter_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    // any byte that may sit alone inside quotes
    function automatic logic [7:0] rnd_lit_ch();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while ((c == 8'h0A) || (c == 8'h5C));
        return c;
    endfunction

    task automatic send_lexeme();
        int         n;
        logic [7:0] c;
        string      s;
        case ($urandom_range(0, 8))
            0: begin
                s = kw_text[$urandom_range(0, 9)];
                for (int i = 0; i < s.len(); i++) put_src(s[i]);
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 3)) put_src(rnd_alnum(1'b0));
                end
            end
            1: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                put_src(rnd_alnum(1'b1));
                repeat (n - 1) put_src(rnd_alnum(1'b0));
            end
            2: begin
                n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 300)
                                                 : $urandom_range(1, 4);
                repeat (n) put_src(8'("0" + $urandom_range(0, 9)));
            end
            3: put_src(op_bytes[$urandom_range(0, 9)]);
            4: repeat ($urandom_range(1, 2)) put_src("=");
            5: put_src("/");
            6: begin
                put_src("/");
                put_src("/");
                repeat ($urandom_range(0, 10)) begin
                    do c = 8'($urandom_range(0, 255)); while (c == 8'h0A);
                    put_src(c);
                end
                // a comment closed by the end word counts no line
                if ($urandom_range(0, 9) == 0) put_end();
                else put_src(8'h0A);
            end
            7: begin
                put_src(8'h27);
                if ($urandom_range(0, 1)) begin
                    put_src(8'h5C);
                    case ($urandom_range(0, 3))
                        0: put_src("n");
                        1: put_src("t");
                        2: put_src(8'h27);
                        default: put_src(8'h5C);
                    endcase
                end else put_src(rnd_lit_ch());
                put_src(8'h27);
            end
            default: repeat ($urandom_range(1, 4)) put_src(ws_bytes[$urandom_range(0, 5)]);
        endcase
    endtask

    task automatic send_bad_literal();
        logic [7:0] c;
        put_src(8'h27);
        case ($urandom_range(0, 5))
            0: put_src(8'h0A);
            1: begin
                put_src(8'h5C);
                if ($urandom_range(0, 3) == 0) c = 8'h0A;
                else begin
                    do c = 8'($urandom_range(0, 255));
                    while ((c == "n") || (c == "t") || (c == 8'h27) || (c == 8'h5C));
                end
                put_src(c);
            end
            2: begin
                put_src(rnd_lit_ch());
                do c = 8'($urandom_range(0, 255)); while (c == 8'h27);
                put_src(c);
            end
            3: begin
                put_src(8'h5C);
                put_end();
            end
            4: put_end();
            default: begin
                put_src(rnd_lit_ch());
                put_end();
            end
        endcase
    endtask

    // receiver back-pressure: stall at a duty level drawn at random from 0, 30, 60 or 90 percent
    always @(posedge i_clk) begin
        if ((n_cyc % 128) == 0) begin
            case ($urandom_range(0, 3))
                0: rx_duty <= 0;
                1: rx_duty <= 30;
                2: rx_duty <= 60;
                default: rx_duty <= 90;
            endcase
        end
        i_out_stall <= ($urandom_range(0, 99) < rx_duty);
    end

    always @(posedge i_clk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc == CYC_LIMIT) begin
            $display("source_text_tokenizer_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin : tok_check
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_tokens.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("unexpected token: kind %0d line %0d off %0d len %0d",
                             o_out_word.token_kind, o_out_word.line,
                             o_out_word.start_offset, o_out_word.token_length);
                end
            end else begin
                e = exp_tokens.pop_front();
                if ((o_out_word.token_kind !== e.token_kind) ||
                    (o_out_word.line !== e.line) ||
                    (o_out_word.start_offset !== e.start_offset) ||
                    (o_out_word.token_length !== e.token_length) ||
                    (o_out_word.char_value !== e.char_value) ||
                    (o_out_word.error_code !== e.error_code) ||
                    (o_out_word.last !== e.last)) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("token mismatch at cycle %0d", n_cyc);
                        $display("  exp kind %0d line %0d off %0d len %0d char %0d err %0d last %0d",
                                 e.token_kind, e.line, e.start_offset, e.token_length,
                                 e.char_value, e.error_code, e.last);
                        $display("  got kind %0d line %0d off %0d len %0d char %0d err %0d last %0d",
                                 o_out_word.token_kind, o_out_word.line,
                                 o_out_word.start_offset, o_out_word.token_length,
                                 o_out_word.char_value, o_out_word.error_code,
                                 o_out_word.last);
                    end
                end
            end
        end
    end

    initial begin
        int pick;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        lx_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[i]) put_word(DIR_TAB[i].word, DIR_TAB[i].chk, DIR_TAB[i].exp);

        while (n_items < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                put_end();
            end else if (pick < 7) begin
                put_src(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) put_end();
            end else if (pick < 10) begin
                send_bad_literal();
                if ($urandom_range(0, 1)) put_end();
            end else begin
                send_lexeme();
                if ($urandom_range(0, 2) == 0) put_src(ws_bytes[$urandom_range(0, 5)]);
            end
        end
        put_end();

        i_in_valid <= 1'b0;
        while (exp_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("source_text_tokenizer_top regression: pass");
        end else begin
            $display("source_text_tokenizer_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/stt_pkg.sv
design/stt_lexer.sv
design/stt_outq.sv
design/source_text_tokenizer_top.sv
design/stt_checker.sv
tb/tb_source_text_tokenizer_top.sv
